@@ design/slc_pkg.sv @@
package slc_pkg;

  // Character codes the scanner looks for
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned TALLY_W = 32;

  // Where the scanner stands within the current line
  typedef enum logic [2:0] {
    PH_START  = 3'd0,  // no byte of the line yet
    PH_LEAD   = 3'd1,  // only white space so far
    PH_SLASH  = 3'd2,  // first non-space byte was a slash
    PH_SKIP   = 3'd3,  // line comment
    PH_CODE   = 3'd4,  // counted line
    PH_OPENED = 3'd5,  // line opened a block comment
    PH_BLOCK  = 3'd6   // line inside an open block comment
  } phase_e;

  // One input word
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic [TALLY_W-1:0] code_lines;
    logic               comment_open;
  } result_t;

  function automatic logic is_white(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

@@ design/slc_if.sv @@
// Input channel: at most one text byte per word
interface slc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, text_byte, byte_present, end_of_text, input ready);
  modport sink   (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

// Result channel: line count at end of text
interface slc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_lines;
  logic        comment_open;

  modport source (output valid, code_lines, comment_open, input ready);
  modport sink   (input valid, code_lines, comment_open, output ready);
endinterface

@@ design/slc_scan.sv @@
// Per-line scanner: holds the line state and the tally, advances one word per step
module slc_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  slc_pkg::in_item_t item_i,
  output slc_pkg::result_t  result_o
);
  import slc_pkg::*;

  phase_e             phase_q, phase_d;
  logic               blk_q, blk_d;
  logic               star_q, star_d;
  logic               close_q, close_d;
  logic [TALLY_W-1:0] tally_q, tally_d;

  // Next line state for one word
  always_comb begin
    logic [7:0] b;
    logic       fin;
    b        = item_i.text_byte;
    phase_d  = phase_q;
    blk_d    = blk_q;
    star_d   = star_q;
    close_d  = close_q;
    tally_d  = tally_q;
    fin      = 1'b0;

    // byte handling
    if (item_i.byte_present) begin
      if (b == CH_NL) begin
        fin = 1'b1;
      end else if (blk_q) begin
        phase_d = PH_BLOCK;
        if (star_q && b == CH_SLASH) close_d = 1'b1;
        star_d = (b == CH_STAR);
      end else begin
        case (phase_q)
          PH_START, PH_LEAD: begin
            if (is_white(b))        phase_d = PH_LEAD;
            else if (b == CH_SLASH) phase_d = PH_SLASH;
            else                    phase_d = PH_CODE;
          end
          PH_SLASH: begin
            if (b == CH_SLASH) begin
              phase_d = PH_SKIP;
            end else if (b == CH_STAR) begin
              phase_d = PH_OPENED;
              star_d  = 1'b1;
            end else begin
              phase_d = PH_CODE;
            end
          end
          PH_OPENED: begin
            if (star_q && b == CH_SLASH) close_d = 1'b1;
            star_d = (b == CH_STAR);
          end
          default: ;
        endcase
      end
    end

    // end of line closes out the current line; end of text does too
    if (fin || item_i.end_of_text) begin
      if (phase_d != PH_START) begin
        if (blk_d) begin
          if (close_d) blk_d = 1'b0;
        end else if (phase_d == PH_OPENED) begin
          blk_d = !close_d;
        end else if (phase_d != PH_SKIP) begin
          tally_d = tally_d + TALLY_W'(1);
        end
      end
      phase_d = PH_START;
      star_d  = 1'b0;
      close_d = 1'b0;
    end

    result_o.code_lines   = tally_d;
    result_o.comment_open = blk_d;

    // report clears everything for the next file
    if (item_i.end_of_text) begin
      blk_d   = 1'b0;
      tally_d = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      blk_q   <= 1'b0;
      star_q  <= 1'b0;
      close_q <= 1'b0;
      tally_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      blk_q   <= blk_d;
      star_q  <= star_d;
      close_q <= close_d;
      tally_q <= tally_d;
    end
  end

endmodule

@@ design/source_line_counter.sv @@
// Channel | Dir | Words                               | Accepted when
// src_i   | in  | text_byte, byte_present, end_of_text | valid && ready
// res_o   | out | code_lines, comment_open             | valid && ready
//
// One word per cycle while no end word stalls; other words are scanned the cycle
// after being taken; a result is registered on its end word and held until taken.
// The input register keeps taking words while a result waits; only an end word
// stalls in the input register until the result register is free.
// Reset clears the line state, the tally and both valid flags.
module source_line_counter (
  input  logic      clk_i,
  input  logic      rst_ni,
  slc_in_if.sink    src_i,
  slc_out_if.source res_o
);
  import slc_pkg::*;

  logic     in_vld_q, in_vld_d;
  in_item_t item_q;
  logic     out_vld_q, out_vld_d;
  result_t  res_q;
  result_t  scan_res;
  logic     out_free, step, take;

  // Handshake control
  assign out_free    = !out_vld_q || res_o.ready;
  assign step        = in_vld_q && (!item_q.end_of_text || out_free);
  assign src_i.ready = !in_vld_q || step;
  assign take        = src_i.valid && src_i.ready;

  assign in_vld_d  = take ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = (step && item_q.end_of_text) ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.text_byte    <= src_i.text_byte;
      item_q.byte_present <= src_i.byte_present;
      item_q.end_of_text  <= src_i.end_of_text;
    end
  end

  slc_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (scan_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && item_q.end_of_text) begin
      res_q <= scan_res;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.code_lines   = res_q.code_lines;
  assign res_o.comment_open = res_q.comment_open;

  // A report never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && item_q.end_of_text && out_vld_q) |-> res_o.ready)
    else $error("result overwritten");

  // A scanned end word always shows up as a result
  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && item_q.end_of_text) |=> out_vld_q)
    else $error("end word gave no result");

  // A held word stays put until scanned
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> (in_vld_q && $stable(item_q)))
    else $error("held word lost");

  // Empty input register always takes a word
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> src_i.ready)
    else $error("empty stage not ready");

endmodule
